// ===== hw/rtl/time_of_day_soft_alarm_defines.svh =====
// assertion macros for the soft alarm block
`ifndef TIME_OF_DAY_SOFT_ALARM_DEFINES_SVH
`define TIME_OF_DAY_SOFT_ALARM_DEFINES_SVH

`ifndef SYNTHESIS
// checked while out of reset
`define TDSA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tdsa assertion failed");
// checked on every edge, reset included
`define TDSA_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("tdsa assertion failed");
`else
`define TDSA_ASSERT(lbl, clk, rst_n, prop)
`define TDSA_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== hw/rtl/tdsa_pkg.sv =====
package tdsa_pkg;

    localparam int W_OPCODE = 2;
    localparam int W_HOUR   = 5;
    localparam int W_MINSEC = 6;
    localparam int W_SECS   = 17;
    localparam int W_REST   = 12;
    localparam int W_REM    = 19;

    localparam logic [W_OPCODE-1:0] OP_ARM       = 2'd0;
    localparam logic [W_OPCODE-1:0] OP_SET_CLOCK = 2'd1;
    localparam logic [W_OPCODE-1:0] OP_QUERY     = 2'd2;

    localparam logic [W_SECS-1:0]   SECS_PER_DAY  = 17'd86400;
    localparam logic [W_SECS-1:0]   SECS_PER_HOUR = 17'd3600;
    localparam logic [W_SECS-1:0]   SECS_PER_MIN  = 17'd60;
    localparam logic [W_SECS-1:0]   MAX_GAP       = 17'd86399;
    localparam logic [W_HOUR-1:0]   MAX_HOUR      = 5'd23;
    localparam logic [W_MINSEC-1:0] MAX_MIN_SEC   = 6'd59;

    localparam logic signed [W_REM-1:0] SECS_PER_DAY_S = 19'sd86400;

    typedef struct packed {
        logic [W_OPCODE-1:0] opcode;
        logic [W_HOUR-1:0]   cur_hour;
        logic [W_MINSEC-1:0] cur_minute;
        logic [W_MINSEC-1:0] cur_second;
        logic [W_SECS-1:0]   gap_secs;
        logic [W_HOUR-1:0]   new_hour;
        logic [W_MINSEC-1:0] new_minute;
        logic [W_MINSEC-1:0] new_second;
    } t_in_item;

    typedef struct packed {
        logic signed [W_REM-1:0] rem;
        logic [W_SECS-1:0]       secs;
        logic                    next_day;
    } t_alarm_word;

    function automatic logic [W_HOUR-1:0] clamp_hour(input logic [W_HOUR-1:0] h);
        return (h > MAX_HOUR) ? MAX_HOUR : h;
    endfunction

    function automatic logic [W_MINSEC-1:0] clamp_minsec(input logic [W_MINSEC-1:0] v);
        return (v > MAX_MIN_SEC) ? MAX_MIN_SEC : v;
    endfunction

    function automatic logic [W_SECS-1:0] to_secs(input logic [W_HOUR-1:0] h,
                                                  input logic [W_MINSEC-1:0] m,
                                                  input logic [W_MINSEC-1:0] s);
        logic [W_SECS-1:0] hs;
        logic [W_SECS-1:0] ms;
        hs = W_SECS'(clamp_hour(h)) * SECS_PER_HOUR;
        ms = W_SECS'(clamp_minsec(m)) * SECS_PER_MIN;
        return hs + ms + W_SECS'(clamp_minsec(s));
    endfunction

endpackage

// ===== hw/rtl/tdsa_if.sv =====
interface tdsa_in_if;
    logic                          valid;
    logic                          ready;
    logic [tdsa_pkg::W_OPCODE-1:0] opcode;
    logic [tdsa_pkg::W_HOUR-1:0]   cur_hour;
    logic [tdsa_pkg::W_MINSEC-1:0] cur_minute;
    logic [tdsa_pkg::W_MINSEC-1:0] cur_second;
    logic [tdsa_pkg::W_SECS-1:0]   gap_secs;
    logic [tdsa_pkg::W_HOUR-1:0]   new_hour;
    logic [tdsa_pkg::W_MINSEC-1:0] new_minute;
    logic [tdsa_pkg::W_MINSEC-1:0] new_second;

    modport source (
        output valid, opcode, cur_hour, cur_minute, cur_second, gap_secs,
               new_hour, new_minute, new_second,
        input  ready
    );
    modport sink (
        input  valid, opcode, cur_hour, cur_minute, cur_second, gap_secs,
               new_hour, new_minute, new_second,
        output ready
    );
endinterface

interface tdsa_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [tdsa_pkg::W_REM-1:0] remaining_seconds;
    logic [tdsa_pkg::W_HOUR-1:0]      alarm_hour_out;
    logic [tdsa_pkg::W_MINSEC-1:0]    alarm_minute_out;
    logic [tdsa_pkg::W_MINSEC-1:0]    alarm_second_out;
    logic                             next_day_out;

    modport source (
        output valid, remaining_seconds, alarm_hour_out, alarm_minute_out,
               alarm_second_out, next_day_out,
        input  ready
    );
    modport sink (
        input  valid, remaining_seconds, alarm_hour_out, alarm_minute_out,
               alarm_second_out, next_day_out,
        output ready
    );
endinterface

// ===== hw/rtl/tdsa_hms_split.sv =====
`include "time_of_day_soft_alarm_defines.svh"

module tdsa_hms_split (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  tdsa_pkg::t_alarm_word i_word,
    tdsa_out_if.source            o_out
);

    logic                              r_c_valid;
    logic [tdsa_pkg::W_HOUR-1:0]       r_c_hour;
    logic [tdsa_pkg::W_REST-1:0]       r_c_rest;
    logic signed [tdsa_pkg::W_REM-1:0] r_c_rem;
    logic                              r_c_next_day;

    logic                              r_o_valid;
    logic [tdsa_pkg::W_HOUR-1:0]       r_o_hour;
    logic [tdsa_pkg::W_MINSEC-1:0]     r_o_minute;
    logic [tdsa_pkg::W_MINSEC-1:0]     r_o_second;
    logic signed [tdsa_pkg::W_REM-1:0] r_o_rem;
    logic                              r_o_next_day;

    logic [tdsa_pkg::W_HOUR-1:0]   n_c_hour;
    logic [tdsa_pkg::W_REST-1:0]   n_c_rest;
    logic [tdsa_pkg::W_MINSEC-1:0] n_o_minute;
    logic [tdsa_pkg::W_MINSEC-1:0] n_o_second;
    logic [tdsa_pkg::W_SECS-1:0]   hour_base;
    logic [tdsa_pkg::W_REST-1:0]   min_base;
    logic                          c_adv;

    assign c_adv   = !r_o_valid || o_out.ready;
    assign o_ready = !r_c_valid || c_adv;

    // hours by comparison against each hour boundary
    always_comb begin
        n_c_hour  = '0;
        hour_base = '0;
        for (int k = 1; k < 24; k++) begin
            if (i_word.secs >= tdsa_pkg::W_SECS'(k * tdsa_pkg::SECS_PER_HOUR)) begin
                n_c_hour  = tdsa_pkg::W_HOUR'(k);
                hour_base = tdsa_pkg::W_SECS'(k * tdsa_pkg::SECS_PER_HOUR);
            end
        end
        n_c_rest = tdsa_pkg::W_REST'(i_word.secs - hour_base);
    end

    // minutes within the hour, same scheme
    always_comb begin
        n_o_minute = '0;
        min_base   = '0;
        for (int k = 1; k < 60; k++) begin
            if (r_c_rest >= tdsa_pkg::W_REST'(k * tdsa_pkg::SECS_PER_MIN)) begin
                n_o_minute = tdsa_pkg::W_MINSEC'(k);
                min_base   = tdsa_pkg::W_REST'(k * tdsa_pkg::SECS_PER_MIN);
            end
        end
        n_o_second = tdsa_pkg::W_MINSEC'(r_c_rest - min_base);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_c_valid <= i_valid;
            end
            if (c_adv) begin
                r_o_valid <= r_c_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_c_hour     <= n_c_hour;
            r_c_rest     <= n_c_rest;
            r_c_rem      <= i_word.rem;
            r_c_next_day <= i_word.next_day;
        end
        if (r_c_valid && c_adv) begin
            r_o_hour     <= r_c_hour;
            r_o_minute   <= n_o_minute;
            r_o_second   <= n_o_second;
            r_o_rem      <= r_c_rem;
            r_o_next_day <= r_c_next_day;
        end
    end

    assign o_out.valid             = r_o_valid;
    assign o_out.remaining_seconds = r_o_rem;
    assign o_out.alarm_hour_out    = r_o_hour;
    assign o_out.alarm_minute_out  = r_o_minute;
    assign o_out.alarm_second_out  = r_o_second;
    assign o_out.next_day_out      = r_o_next_day;

    `TDSA_ASSERT(a_rest_below_hour, i_clk, i_rst_n,
        r_c_valid |-> (r_c_rest < tdsa_pkg::W_REST'(tdsa_pkg::SECS_PER_HOUR)))
    `TDSA_ASSERT(a_out_in_range, i_clk, i_rst_n,
        r_o_valid |-> (r_o_hour <= tdsa_pkg::MAX_HOUR
                       && r_o_minute <= tdsa_pkg::MAX_MIN_SEC
                       && r_o_second <= tdsa_pkg::MAX_MIN_SEC))
    `TDSA_ASSERT(a_word_taken, i_clk, i_rst_n,
        (i_valid && o_ready) |=> r_c_valid)

endmodule

// ===== hw/rtl/time_of_day_soft_alarm.sv =====
// soft alarm held as a time of day
// input channel i_in: one transaction per item, carrying the opcode, the
// current clock time, the arm gap and the new clock time for set clock
// output channel o_out: exactly one transaction per accepted item, in order,
// carrying the remaining seconds (query only, else zero) and the stored alarm
// hour, minute, second and next-day flag after that item
// an accepted item passes the input register, the alarm update, the hour split
// and the minute split into the output register; throughput is one item per
// cycle while the receiver does not stall, set by the alarm update stage
// which reads and writes the alarm state in the same cycle
// the alarm is held internally as seconds of day and split into hours,
// minutes and seconds over two pipeline stages on the way out
// reset (synchronous, active low) clears the alarm, the next-day flag, the
// last seen hour and every stage; no clearing pass is needed
// when the receiver stalls the stages fill up behind the output register
// and i_in.ready drops only once every stage holds an item; nothing is lost
`include "time_of_day_soft_alarm_defines.svh"

module time_of_day_soft_alarm (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tdsa_in_if.sink    i_in,
    tdsa_out_if.source o_out
);

    logic                        r_a_valid;
    tdsa_pkg::t_in_item          r_a_item;
    logic                        r_b_valid;
    tdsa_pkg::t_alarm_word       r_b_word;
    logic [tdsa_pkg::W_SECS-1:0] r_alarm_secs;
    logic                        r_next_day;
    logic [tdsa_pkg::W_HOUR-1:0] r_prev_hour;

    logic [tdsa_pkg::W_SECS-1:0] n_alarm_secs;
    logic                        n_next_day;
    logic [tdsa_pkg::W_HOUR-1:0] n_prev_hour;
    tdsa_pkg::t_alarm_word       n_b_word;

    logic                              in_ready;
    logic                              a_adv;
    logic                              a_move;
    logic                              split_ready;
    logic [tdsa_pkg::W_HOUR-1:0]       hour_c;
    logic [tdsa_pkg::W_SECS-1:0]       now_s;
    logic [tdsa_pkg::W_SECS-1:0]       new_s;
    logic [tdsa_pkg::W_SECS-1:0]       gap_c;
    logic [tdsa_pkg::W_SECS:0]         sum_arm;
    logic signed [tdsa_pkg::W_REM-1:0] sum_set;
    logic signed [tdsa_pkg::W_REM-1:0] rem;
    logic                              nd_query;

    assign a_adv     = !r_b_valid || split_ready;
    assign a_move    = r_a_valid && a_adv;
    assign in_ready  = !r_a_valid || a_adv;
    assign i_in.ready = in_ready;

    always_comb begin
        hour_c   = tdsa_pkg::clamp_hour(r_a_item.cur_hour);
        now_s    = tdsa_pkg::to_secs(r_a_item.cur_hour, r_a_item.cur_minute,
                                     r_a_item.cur_second);
        new_s    = tdsa_pkg::to_secs(r_a_item.new_hour, r_a_item.new_minute,
                                     r_a_item.new_second);
        gap_c    = (r_a_item.gap_secs > tdsa_pkg::MAX_GAP) ? tdsa_pkg::MAX_GAP
                                                            : r_a_item.gap_secs;
        sum_arm  = {1'b0, now_s} + {1'b0, gap_c};
        sum_set  = $signed({2'b00, r_alarm_secs}) + $signed({2'b00, new_s})
                 - $signed({2'b00, now_s});
        nd_query = (hour_c == '0 && r_prev_hour == tdsa_pkg::MAX_HOUR) ? 1'b0
                                                                       : r_next_day;

        n_alarm_secs = r_alarm_secs;
        n_next_day   = r_next_day;
        n_prev_hour  = r_prev_hour;
        rem          = '0;

        unique case (r_a_item.opcode)
            tdsa_pkg::OP_ARM: begin
                if (sum_arm >= {1'b0, tdsa_pkg::SECS_PER_DAY}) begin
                    n_alarm_secs = tdsa_pkg::W_SECS'(sum_arm - {1'b0, tdsa_pkg::SECS_PER_DAY});
                    n_next_day   = 1'b1;
                end else begin
                    n_alarm_secs = sum_arm[tdsa_pkg::W_SECS-1:0];
                end
            end
            tdsa_pkg::OP_SET_CLOCK: begin
                if (sum_set >= tdsa_pkg::SECS_PER_DAY_S) begin
                    n_alarm_secs = tdsa_pkg::W_SECS'(sum_set - tdsa_pkg::SECS_PER_DAY_S);
                    n_next_day   = 1'b1;
                end else if (sum_set < 0) begin
                    n_alarm_secs = tdsa_pkg::W_SECS'(sum_set + tdsa_pkg::SECS_PER_DAY_S);
                end else begin
                    n_alarm_secs = sum_set[tdsa_pkg::W_SECS-1:0];
                end
            end
            tdsa_pkg::OP_QUERY: begin
                n_next_day  = nd_query;
                n_prev_hour = hour_c;
                rem = $signed({2'b00, r_alarm_secs})
                    + (nd_query ? tdsa_pkg::SECS_PER_DAY_S : '0)
                    - $signed({2'b00, now_s});
            end
            default: begin
                // unused opcode leaves the state alone
            end
        endcase

        n_b_word.rem      = rem;
        n_b_word.secs     = n_alarm_secs;
        n_b_word.next_day = n_next_day;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid    <= 1'b0;
            r_b_valid    <= 1'b0;
            r_alarm_secs <= '0;
            r_next_day   <= 1'b0;
            r_prev_hour  <= '0;
        end else begin
            if (in_ready) begin
                r_a_valid <= i_in.valid;
            end
            if (a_adv) begin
                r_b_valid <= r_a_valid;
            end
            if (a_move) begin
                r_alarm_secs <= n_alarm_secs;
                r_next_day   <= n_next_day;
                r_prev_hour  <= n_prev_hour;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && in_ready) begin
            r_a_item.opcode     <= i_in.opcode;
            r_a_item.cur_hour   <= i_in.cur_hour;
            r_a_item.cur_minute <= i_in.cur_minute;
            r_a_item.cur_second <= i_in.cur_second;
            r_a_item.gap_secs   <= i_in.gap_secs;
            r_a_item.new_hour   <= i_in.new_hour;
            r_a_item.new_minute <= i_in.new_minute;
            r_a_item.new_second <= i_in.new_second;
        end
        if (a_move) begin
            r_b_word <= n_b_word;
        end
    end

    tdsa_hms_split u_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_b_valid),
        .o_ready (split_ready),
        .i_word  (r_b_word),
        .o_out   (o_out)
    );

    `TDSA_ASSERT(a_alarm_in_day, i_clk, i_rst_n, r_alarm_secs < tdsa_pkg::SECS_PER_DAY)
    `TDSA_ASSERT(a_stall_holds, i_clk, i_rst_n,
        (r_a_valid && !a_adv) |=> (r_a_valid && $stable(r_a_item)))
    `TDSA_ASSERT(a_flag_clears_on_query, i_clk, i_rst_n,
        ($fell(r_next_day) && $past(i_rst_n))
            |-> $past(a_move && r_a_item.opcode == tdsa_pkg::OP_QUERY))

endmodule
